/* rtl/packbits_rle_byte_encoder_macros.svh */
// Assertion helpers for the PackBits encoder.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef PACKBITS_RLE_BYTE_ENCODER_MACROS_SVH
`define PACKBITS_RLE_BYTE_ENCODER_MACROS_SVH

// Same-cycle implication.
`define PBRE_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PBRE_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pbre_pkg.sv */
package pbre_pkg;

    localparam int MAX_CHUNK  = 128;
    localparam int LIT_DEPTH  = 130;
    localparam int LIT_AW     = $clog2(LIT_DEPTH);
    localparam int FILL_W     = $clog2(LIT_DEPTH + 1);
    localparam int RUN_W      = $clog2(MAX_CHUNK + 2);
    localparam int WORD_BYTES = 8;
    localparam int ACC_W      = $clog2(WORD_BYTES + 1);
    localparam int RUN_BIAS   = 257;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h00;

    typedef logic [7:0]                byte_t;
    typedef logic [8*WORD_BYTES-1:0]   word_t;
    typedef logic [LIT_AW-1:0]         addr_t;
    typedef logic [FILL_W-1:0]         fill_t;
    typedef logic [RUN_W-1:0]          run_t;
    typedef logic [ACC_W-1:0]          acc_cnt_t;

endpackage

/* rtl/packbits_rle_byte_encoder.sv */
// PackBits run-length encoder for one byte stream.
// Input channel (in_valid / in_stall, fields cmd and data_byte): one transaction
// carries either a data byte (cmd = 0) or an end-of-segment mark (cmd = 1) that
// flushes pending literals and runs and pads the segment to even length.
// Output channel (out_valid / out_stall, fields out_word, byte_count, last):
// encoded bytes packed into 64-bit words, first byte in bits 7..0, unused
// upper bytes zero; last marks the final word caused by one input transaction.
// in_stall is high while an input transaction is being worked on; a small
// sequencer drives one shared byte path that moves one encoded byte per cycle
// into the word packer while it has room, so the packer and the literal store
// port set the rate. A data byte that only updates run state still walks its
// sequencer states, and a literal flush emits a header and up to 128 bytes.
// A word moves to the output register when a ninth byte needs its slot or when
// the transaction ends; out_valid is registered and rises with the word.
// When the receiver stalls, the output register holds its word and the
// sequencer waits on a full packer or a pending last word; nothing is dropped.
// Reset (rst_n low, asynchronous) clears run state, literal count, parity and
// both handshakes; the literal store needs no clearing, since only written
// entries are ever read.
`include "packbits_rle_byte_encoder_macros.svh"

module packbits_rle_byte_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_word,
    output logic [3:0]  byte_count,
    output logic        last
);

    localparam int MAX_CHUNK  = pbre_pkg::MAX_CHUNK;
    localparam int LIT_DEPTH  = pbre_pkg::LIT_DEPTH;
    localparam int WORD_BYTES = pbre_pkg::WORD_BYTES;

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SAME      = 4'd1;
    localparam logic [3:0] S_SPLIT     = 4'd2;
    localparam logic [3:0] S_DIFF      = 4'd3;
    localparam logic [3:0] S_PUSH      = 4'd4;
    localparam logic [3:0] S_OVER      = 4'd5;
    localparam logic [3:0] S_END       = 4'd6;
    localparam logic [3:0] S_END_DRAIN = 4'd7;
    localparam logic [3:0] S_END_RUN   = 4'd8;
    localparam logic [3:0] S_END_PAD   = 4'd9;
    localparam logic [3:0] S_LIT_HDR   = 4'd10;
    localparam logic [3:0] S_LIT_BODY  = 4'd11;
    localparam logic [3:0] S_RUN_CODE  = 4'd12;
    localparam logic [3:0] S_RUN_VAL   = 4'd13;
    localparam logic [3:0] S_FINISH    = 4'd14;

    // Sequencer and encoder state
    logic [3:0]         state_reg, state_next;
    logic [3:0]         lit_ret_reg, lit_ret_next;   // return after one literal chunk
    logic [3:0]         seq_ret_reg, seq_ret_next;   // return after pushes or runs
    logic               run_loop_reg, run_loop_next;
    logic [1:0]         push_left_reg, push_left_next;
    pbre_pkg::byte_t    cur_byte_reg, cur_byte_next;
    logic               prev_valid_reg, prev_valid_next;
    pbre_pkg::byte_t    prev_value_reg, prev_value_next;
    pbre_pkg::run_t     repeat_reg, repeat_next;
    pbre_pkg::fill_t    fill_reg, fill_next;
    pbre_pkg::fill_t    chunk_left_reg, chunk_left_next;
    pbre_pkg::addr_t    head_reg, head_next;
    pbre_pkg::addr_t    tail_reg, tail_next;
    logic               odd_reg, odd_next;

    // Word packer and output register
    pbre_pkg::word_t    acc_word_reg, acc_word_next;
    pbre_pkg::acc_cnt_t acc_cnt_reg, acc_cnt_next;
    logic               out_valid_reg, out_valid_next;
    pbre_pkg::word_t    out_word_reg, out_word_next;
    pbre_pkg::acc_cnt_t byte_count_reg, byte_count_next;
    logic               last_reg, last_next;

    // Shared byte path
    logic               push_en;
    pbre_pkg::byte_t    push_data;
    logic               push_room;
    logic               push_fire;
    logic               out_free;
    logic               move_full;
    logic               fin_move;
    pbre_pkg::word_t    acc_base;

    // Literal store port
    logic               wr_en;
    logic               rd_en;
    pbre_pkg::addr_t    rd_addr;
    pbre_pkg::byte_t    rd_data;

    pbre_pkg::addr_t    head_inc;
    pbre_pkg::addr_t    tail_inc;
    pbre_pkg::fill_t    chunk_n;
    pbre_pkg::run_t     run_n;
    pbre_pkg::run_t     repeat_after;

    pbre_ram #(
        .WIDTH(8),
        .DEPTH(LIT_DEPTH)
    ) u_lit_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (prev_value_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Circular literal store pointers
    assign head_inc = (head_reg == pbre_pkg::addr_t'(LIT_DEPTH - 1)) ? '0
                    : pbre_pkg::addr_t'(head_reg + 1'b1);
    assign tail_inc = (tail_reg == pbre_pkg::addr_t'(LIT_DEPTH - 1)) ? '0
                    : pbre_pkg::addr_t'(tail_reg + 1'b1);

    // Packet lengths: a literal chunk and a run packet both cap at MAX_CHUNK
    assign chunk_n = (fill_reg > pbre_pkg::fill_t'(MAX_CHUNK))
                   ? pbre_pkg::fill_t'(MAX_CHUNK) : fill_reg;
    assign run_n   = (repeat_reg > pbre_pkg::run_t'(MAX_CHUNK))
                   ? pbre_pkg::run_t'(MAX_CHUNK) : repeat_reg;
    assign repeat_after = pbre_pkg::run_t'(repeat_reg - run_n);

    // The packer takes a byte unless it is full and the output register is busy
    assign out_free  = !out_valid_reg || !out_stall;
    assign push_room = (acc_cnt_reg != pbre_pkg::acc_cnt_t'(WORD_BYTES)) || out_free;
    assign push_fire = push_en && push_room;

    assign in_stall  = (state_reg != S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        lit_ret_next    = lit_ret_reg;
        seq_ret_next    = seq_ret_reg;
        run_loop_next   = run_loop_reg;
        push_left_next  = push_left_reg;
        cur_byte_next   = cur_byte_reg;
        prev_valid_next = prev_valid_reg;
        prev_value_next = prev_value_reg;
        repeat_next     = repeat_reg;
        fill_next       = fill_reg;
        chunk_left_next = chunk_left_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        push_en         = 1'b0;
        push_data       = '0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_byte_next = data_byte;
                    if (cmd == pbre_pkg::CMD_END)
                    begin
                        state_next = S_END;
                    end
                    else if (prev_valid_reg && data_byte == prev_value_reg)
                    begin
                        repeat_next = pbre_pkg::run_t'(repeat_reg + 1'b1);
                        state_next  = S_SAME;
                    end
                    else
                    begin
                        state_next = S_DIFF;
                    end
                end
            end

            S_SAME:
            begin
                // A run of three or more flushes every pending literal first
                if (repeat_reg > pbre_pkg::run_t'(2) && fill_reg != '0)
                begin
                    lit_ret_next = S_SAME;
                    state_next   = S_LIT_HDR;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end

            S_SPLIT:
            begin
                if (repeat_reg > pbre_pkg::run_t'(MAX_CHUNK))
                begin
                    run_loop_next = 1'b0;
                    seq_ret_next  = S_FINISH;
                    state_next    = S_RUN_CODE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_DIFF:
            begin
                // Retire the previous run: short runs become literals
                if (!prev_valid_reg || repeat_reg == '0)
                begin
                    state_next = S_OVER;
                end
                else if (repeat_reg == pbre_pkg::run_t'(1))
                begin
                    push_left_next = 2'd1;
                    seq_ret_next   = S_OVER;
                    state_next     = S_PUSH;
                end
                else if (repeat_reg == pbre_pkg::run_t'(2))
                begin
                    push_left_next = 2'd2;
                    seq_ret_next   = S_OVER;
                    state_next     = S_PUSH;
                end
                else
                begin
                    run_loop_next = 1'b1;
                    seq_ret_next  = S_OVER;
                    state_next    = S_RUN_CODE;
                end
            end

            S_PUSH:
            begin
                if (fill_reg == pbre_pkg::fill_t'(LIT_DEPTH))
                begin
                    lit_ret_next = S_PUSH;
                    state_next   = S_LIT_HDR;
                end
                else
                begin
                    wr_en          = 1'b1;
                    tail_next      = tail_inc;
                    fill_next      = pbre_pkg::fill_t'(fill_reg + 1'b1);
                    push_left_next = push_left_reg - 2'd1;
                    if (push_left_reg == 2'd1)
                    begin
                        state_next = seq_ret_reg;
                    end
                end
            end

            S_OVER:
            begin
                if (fill_reg > pbre_pkg::fill_t'(MAX_CHUNK))
                begin
                    lit_ret_next = S_OVER;
                    state_next   = S_LIT_HDR;
                end
                else
                begin
                    prev_valid_next = 1'b1;
                    prev_value_next = cur_byte_reg;
                    repeat_next     = pbre_pkg::run_t'(1);
                    state_next      = S_FINISH;
                end
            end

            S_END:
            begin
                // A pending single joins the literals
                if (prev_valid_reg && repeat_reg == pbre_pkg::run_t'(1))
                begin
                    push_left_next = 2'd1;
                    seq_ret_next   = S_END_DRAIN;
                    repeat_next    = '0;
                    state_next     = S_PUSH;
                end
                else
                begin
                    state_next = S_END_DRAIN;
                end
            end

            S_END_DRAIN:
            begin
                if (fill_reg != '0)
                begin
                    lit_ret_next = S_END_DRAIN;
                    state_next   = S_LIT_HDR;
                end
                else
                begin
                    state_next = S_END_RUN;
                end
            end

            S_END_RUN:
            begin
                if (prev_valid_reg && repeat_reg >= pbre_pkg::run_t'(2))
                begin
                    run_loop_next = 1'b1;
                    seq_ret_next  = S_END_PAD;
                    state_next    = S_RUN_CODE;
                end
                else
                begin
                    state_next = S_END_PAD;
                end
            end

            S_END_PAD:
            begin
                prev_valid_next = 1'b0;
                prev_value_next = '0;
                repeat_next     = '0;
                if (odd_reg)
                begin
                    push_en   = 1'b1;
                    push_data = pbre_pkg::PAD_BYTE;
                    if (push_room)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_LIT_HDR:
            begin
                // Header n-1; keep the first literal fetch going meanwhile
                push_en   = 1'b1;
                push_data = pbre_pkg::byte_t'(chunk_n - 1'b1);
                rd_en     = 1'b1;
                rd_addr   = head_reg;
                if (push_room)
                begin
                    chunk_left_next = chunk_n;
                    state_next      = S_LIT_BODY;
                end
            end

            S_LIT_BODY:
            begin
                push_en   = 1'b1;
                push_data = rd_data;
                if (push_room)
                begin
                    head_next       = head_inc;
                    fill_next       = pbre_pkg::fill_t'(fill_reg - 1'b1);
                    chunk_left_next = pbre_pkg::fill_t'(chunk_left_reg - 1'b1);
                    if (chunk_left_reg == pbre_pkg::fill_t'(1))
                    begin
                        state_next = lit_ret_reg;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                    end
                end
            end

            S_RUN_CODE:
            begin
                push_en   = 1'b1;
                push_data = pbre_pkg::byte_t'(pbre_pkg::RUN_BIAS - int'(run_n));
                if (push_room)
                begin
                    state_next = S_RUN_VAL;
                end
            end

            S_RUN_VAL:
            begin
                push_en   = 1'b1;
                push_data = prev_value_reg;
                if (push_room)
                begin
                    repeat_next = repeat_after;
                    if (run_loop_reg && repeat_after != '0)
                    begin
                        state_next = S_RUN_CODE;
                    end
                    else
                    begin
                        state_next = seq_ret_reg;
                    end
                end
            end

            S_FINISH:
            begin
                // Hand the pending word, if any, over as the last one of this transaction
                if (acc_cnt_reg == '0 || out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Word packer and output register
    assign move_full = push_fire && (acc_cnt_reg == pbre_pkg::acc_cnt_t'(WORD_BYTES));
    assign fin_move  = (state_reg == S_FINISH) && (acc_cnt_reg != '0) && out_free;

    always_comb
    begin
        acc_word_next   = acc_word_reg;
        acc_cnt_next    = acc_cnt_reg;
        odd_next        = odd_reg;
        out_valid_next  = out_valid_reg;
        out_word_next   = out_word_reg;
        byte_count_next = byte_count_reg;
        last_next       = last_reg;

        // Start from a clean word when empty or when the full word leaves now
        acc_base = (acc_cnt_reg == '0 || acc_cnt_reg == pbre_pkg::acc_cnt_t'(WORD_BYTES))
                 ? '0 : acc_word_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (push_fire)
        begin
            odd_next = !odd_reg;
            acc_base[8*acc_cnt_reg[2:0] +: 8] = push_data;
            acc_word_next = acc_base;
            if (move_full)
            begin
                acc_cnt_next = pbre_pkg::acc_cnt_t'(1);
            end
            else
            begin
                acc_cnt_next = pbre_pkg::acc_cnt_t'(acc_cnt_reg + 1'b1);
            end
        end

        if (move_full)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = acc_word_reg;
            byte_count_next = acc_cnt_reg;
            last_next       = 1'b0;
        end
        else if (fin_move)
        begin
            out_valid_next  = 1'b1;
            out_word_next   = acc_word_reg;
            byte_count_next = acc_cnt_reg;
            last_next       = 1'b1;
            acc_cnt_next    = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            lit_ret_reg    <= S_IDLE;
            seq_ret_reg    <= S_IDLE;
            run_loop_reg   <= 1'b0;
            push_left_reg  <= '0;
            prev_valid_reg <= 1'b0;
            prev_value_reg <= '0;
            repeat_reg     <= '0;
            fill_reg       <= '0;
            chunk_left_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            odd_reg        <= 1'b0;
            acc_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            lit_ret_reg    <= lit_ret_next;
            seq_ret_reg    <= seq_ret_next;
            run_loop_reg   <= run_loop_next;
            push_left_reg  <= push_left_next;
            prev_valid_reg <= prev_valid_next;
            prev_value_reg <= prev_value_next;
            repeat_reg     <= repeat_next;
            fill_reg       <= fill_next;
            chunk_left_reg <= chunk_left_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            odd_reg        <= odd_next;
            acc_cnt_reg    <= acc_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cur_byte_reg   <= cur_byte_next;
        acc_word_reg   <= acc_word_next;
        out_word_reg   <= out_word_next;
        byte_count_reg <= byte_count_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_word   = out_word_reg;
    assign byte_count = byte_count_reg;
    assign last       = last_reg;

    // Checks
    `PBRE_IMPLIES(a_idle_packer_empty, state_reg == S_IDLE, acc_cnt_reg == '0,
                  "packer not flushed at end of transaction")
    `PBRE_IMPLIES(a_idle_fill_bound, state_reg == S_IDLE,
                  fill_reg <= pbre_pkg::fill_t'(MAX_CHUNK),
                  "literal backlog above one chunk while idle")
    `PBRE_IMPLIES(a_body_has_data, state_reg == S_LIT_BODY,
                  fill_reg != '0 && chunk_left_reg != '0,
                  "literal drain with empty store")
    `PBRE_NEXT(a_word_count, move_full || fin_move,
               out_valid_reg && byte_count_reg != '0,
               "output word loaded without bytes")

endmodule

/* rtl/pbre_ram.sv */
module pbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 130
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
